/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks of the coordinate transform.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds whenever the block is out of reset.
`define P2CT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("p2ct assertion failed");

// Check that holds at every edge, reset included.
`define P2CT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("p2ct assertion failed");

`endif

/* src/p2ct_pkg.sv */
// ----------------------------------------------------------------------------
// p2ct_pkg
// Types, constants and small helpers of the polynomial coordinate transform.
// ----------------------------------------------------------------------------
package p2ct_pkg;

   // Default sizes.
   localparam int MAX_TERMS_DEF   = 21;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 64;

   // Fixed formats and coefficient layout.
   localparam int COORD_FRAC = 16;
   localparam int ENTRIES    = 22;
   localparam int NUM_COEF   = 4 * ENTRIES;
   localparam int ADDR_W     = 7;
   localparam int NUM_POW    = 6;
   localparam int POW_W      = 3;

   localparam logic signed [63:0] ONE_Q = 64'sd1 <<< COORD_FRAC;

   // Request kinds.
   localparam logic CMD_LOAD      = 1'b0;
   localparam logic CMD_TRANSFORM = 1'b1;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_DIRECTION = 2'd0;
   localparam logic [1:0] CSR_TERMS_X   = 2'd1;
   localparam logic [1:0] CSR_TERMS_Y   = 2'd2;

   // Multiply unit request and response.
   typedef struct packed {
      logic              start;
      logic              coef_shift;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic              ovf;
      logic signed [63:0] value;
   } mul_rsp_type;

   // Flat coefficient address of (set, axis, index).
   function automatic logic [ADDR_W-1:0] coef_addr(input logic set, input logic axis,
                                                   input logic [4:0] idx);
      coef_addr = ADDR_W'({set, axis}) * ADDR_W'(ENTRIES) + ADDR_W'(idx);
   endfunction

   // Power of x used by each monomial term.
   function automatic logic [POW_W-1:0] exp_x(input logic [4:0] k);
      logic [POW_W-1:0] e;
      case (k)
         5'd2, 5'd4, 5'd8, 5'd13, 5'd19: e = 3'd1;
         5'd5, 5'd7, 5'd11, 5'd17:       e = 3'd2;
         5'd9, 5'd12, 5'd16:             e = 3'd3;
         5'd14, 5'd18:                   e = 3'd4;
         5'd20:                          e = 3'd5;
         default:                        e = 3'd0;
      endcase
      exp_x = e;
   endfunction

   // Power of y used by each monomial term.
   function automatic logic [POW_W-1:0] exp_y(input logic [4:0] k);
      logic [POW_W-1:0] e;
      case (k)
         5'd3, 5'd4, 5'd7, 5'd12, 5'd18: e = 3'd1;
         5'd6, 5'd8, 5'd11, 5'd16:       e = 3'd2;
         5'd10, 5'd13, 5'd17:            e = 3'd3;
         5'd15, 5'd19:                   e = 3'd4;
         5'd21:                          e = 3'd5;
         default:                        e = 3'd0;
      endcase
      exp_y = e;
   endfunction

endpackage

/* src/p2ct_front.sv */
// ----------------------------------------------------------------------------
// p2ct_front
// Accepts requests, drops loads with an index past the table and packs the
// rest with their flat coefficient address for the queue.
// ----------------------------------------------------------------------------
module p2ct_front #(
   parameter int COORD_WIDTH = p2ct_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = p2ct_pkg::COEF_WIDTH_DEF
) (
   input  logic                                                 req_tvalid,
   output logic                                                 req_tready,
   input  logic [((7+COEF_WIDTH+2*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   input  logic                                                 req_tuser,
   output logic                                                 q_valid,
   input  logic                                                 q_ready,
   output logic [1+p2ct_pkg::ADDR_W+COEF_WIDTH+2*COORD_WIDTH-1:0] q_data
);
   import p2ct_pkg::*;

   localparam int VAL_LO = 7;
   localparam int PX_LO  = VAL_LO + COEF_WIDTH;
   localparam int PY_LO  = PX_LO + COORD_WIDTH;

   logic                   is_xform;
   logic [4:0]             idx;
   logic                   keep;
   logic [ADDR_W-1:0]      addr;

   // Classify the request.
   assign is_xform = (req_tuser == CMD_TRANSFORM);
   assign idx      = req_tdata[6:2];
   assign keep     = is_xform || (idx < 5'(ENTRIES));
   assign addr     = coef_addr(req_tdata[0], req_tdata[1], idx);

   // Dropped loads are still consumed.
   assign req_tready = q_ready;
   assign q_valid    = req_tvalid && keep;
   assign q_data     = {is_xform, addr,
                        req_tdata[PX_LO-1:VAL_LO],
                        req_tdata[PY_LO-1:PX_LO],
                        req_tdata[PY_LO+COORD_WIDTH-1:PY_LO]};

endmodule

/* src/p2ct_queue.sv */
// ----------------------------------------------------------------------------
// p2ct_queue
// Two-entry queue between the request front and the execution back end.
// ----------------------------------------------------------------------------
module p2ct_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);
   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

endmodule

/* src/p2ct_mul.sv */
// ----------------------------------------------------------------------------
// p2ct_mul
// Shared 64 by 64 multiply with floor shift and saturation. The magnitude
// product is built from four 32 by 32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module p2ct_mul #(
   parameter int COEF_WIDTH = p2ct_pkg::COEF_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  p2ct_pkg::mul_req_type  mul_req,
   output p2ct_pkg::mul_rsp_type  mul_rsp
);
   import p2ct_pkg::*;

   localparam int COEF_FRAC = COEF_WIDTH - 24;

   logic [63:0]        ua_ff, ub_ff;
   logic               neg_ff, sel_ff;
   logic [127:0]       prod_ff;
   logic [2:0]         step_ff;
   logic               run_ff;
   logic               done_ff, ovf_ff;
   logic signed [63:0] value_ff;

   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] pp_sh;
   logic [127:0] q, qr;
   logic         rem;
   logic         f_ovf;
   logic [63:0]  f_val;

   // Partial product of the current step.
   assign a_half = step_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
   assign b_half = step_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
   assign pp     = 64'(a_half) * 64'(b_half);

   always_comb begin
      if (step_ff[1] && step_ff[0])      pp_sh = 128'(pp) << 64;
      else if (step_ff[1] || step_ff[0]) pp_sh = 128'(pp) << 32;
      else                               pp_sh = 128'(pp);
   end

   // Floor shift, rounding of negative results and saturation.
   always_comb begin
      if (sel_ff) begin
         q   = prod_ff >> COEF_FRAC;
         rem = |prod_ff[COEF_FRAC-1:0];
      end else begin
         q   = prod_ff >> COORD_FRAC;
         rem = |prod_ff[COORD_FRAC-1:0];
      end
      qr = q + 128'(neg_ff && rem);
      f_ovf = 1'b0;
      if (neg_ff) begin
         if (qr > (128'd1 << 63)) begin
            f_ovf = 1'b1;
            f_val = 64'h8000_0000_0000_0000;
         end else begin
            f_val = 64'd0 - qr[63:0];
         end
      end else begin
         if (qr > 128'h7FFF_FFFF_FFFF_FFFF) begin
            f_ovf = 1'b1;
            f_val = 64'h7FFF_FFFF_FFFF_FFFF;
         end else begin
            f_val = qr[63:0];
         end
      end
   end

   // Operand capture and accumulation.
   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         ua_ff   <= mul_req.a[63] ? 64'd0 - mul_req.a : mul_req.a;
         ub_ff   <= mul_req.b[63] ? 64'd0 - mul_req.b : mul_req.b;
         neg_ff  <= mul_req.a[63] != mul_req.b[63];
         sel_ff  <= mul_req.coef_shift;
         prod_ff <= 128'd0;
      end else if (run_ff && (step_ff != 3'd4)) begin
         prod_ff <= prod_ff + pp_sh;
      end
      if (run_ff && (step_ff == 3'd4)) begin
         value_ff <= f_val;
         ovf_ff   <= f_ovf;
      end
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            run_ff  <= 1'b1;
            step_ff <= 3'd0;
         end else if (run_ff) begin
            if (step_ff == 3'd4) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 3'd1;
            end
         end
      end
   end

   assign mul_rsp.done  = done_ff;
   assign mul_rsp.ovf   = ovf_ff;
   assign mul_rsp.value = value_ff;

endmodule

/* src/p2ct_back.sv */
// ----------------------------------------------------------------------------
// p2ct_back
// Executes queued requests: coefficient writes into the store, and the
// polynomial evaluation of points through the shared multiply unit.
// ----------------------------------------------------------------------------
module p2ct_back #(
   parameter int MAX_TERMS   = p2ct_pkg::MAX_TERMS_DEF,
   parameter int COORD_WIDTH = p2ct_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = p2ct_pkg::COEF_WIDTH_DEF
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 q_valid,
   output logic                                                 q_ready,
   input  logic [1+p2ct_pkg::ADDR_W+COEF_WIDTH+2*COORD_WIDTH-1:0] q_data,
   input  logic                                                 direction,
   input  logic [4:0]                                           terms_x,
   input  logic [4:0]                                           terms_y,
   output p2ct_pkg::mul_req_type                                mul_req,
   input  p2ct_pkg::mul_rsp_type                                mul_rsp,
   output logic                                                 rsp_valid,
   input  logic                                                 rsp_ready,
   output logic signed [COORD_WIDTH-1:0]                        out_x,
   output logic signed [COORD_WIDTH-1:0]                        out_y,
   output logic                                                 overflow
);
   import p2ct_pkg::*;

   localparam int COEF_FRAC = COEF_WIDTH - 24;
   localparam int OFF_S     = COEF_FRAC - COORD_FRAC;
   localparam int OFF_R     = (OFF_S >= 0) ? OFF_S : 0;
   localparam int OFF_L     = (OFF_S < 0) ? -OFF_S : 0;
   localparam logic signed [63:0] C_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] C_LO = -C_HI - 64'sd1;
   localparam int PY_LO  = 0;
   localparam int PX_LO  = COORD_WIDTH;
   localparam int VAL_LO = 2 * COORD_WIDTH;
   localparam int ADR_LO = VAL_LO + COEF_WIDTH;
   localparam int TOP    = ADR_LO + ADDR_W;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_OFFX   = 4'd1;
   localparam logic [3:0] ST_OFFY   = 4'd2;
   localparam logic [3:0] ST_PSTART = 4'd3;
   localparam logic [3:0] ST_PWAIT  = 4'd4;
   localparam logic [3:0] ST_TSTART = 4'd5;
   localparam logic [3:0] ST_MONO   = 4'd6;
   localparam logic [3:0] ST_TERM   = 4'd7;
   localparam logic [3:0] ST_OFFOUT = 4'd8;
   localparam logic [3:0] ST_DONE   = 4'd9;

   // Saturating 64-bit add; the top bit of the result flags overflow.
   function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s[64] != s[63]) sat_add = {1'b1, s[64] ? 64'h8000_0000_0000_0000
                                                 : 64'h7FFF_FFFF_FFFF_FFFF};
      else                sat_add = {1'b0, s[63:0]};
   endfunction

   // Clamp to the coordinate range; the top bit flags overflow.
   function automatic logic [64:0] clamp_c(input logic signed [63:0] v);
      if (v > C_HI)      clamp_c = {1'b1, C_HI};
      else if (v < C_LO) clamp_c = {1'b1, C_LO};
      else               clamp_c = {1'b0, v};
   endfunction

   logic [COEF_WIDTH-1:0] coef_mem [NUM_COEF];
   logic signed [COEF_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  we;

   logic [3:0]  state_ff, state_in;
   logic        set_ff, set_in;
   logic signed [COORD_WIDTH-1:0] ptx_ff, ptx_in, pty_ff, pty_in;
   logic signed [63:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [63:0] pl_ff, pl_in;
   logic        pol_ff, pol_in;
   logic signed [63:0] pwx_ff [NUM_POW];
   logic signed [63:0] pwx_in [NUM_POW];
   logic signed [63:0] pwy_ff [NUM_POW];
   logic signed [63:0] pwy_in [NUM_POW];
   logic [NUM_POW-1:0] povx_ff, povx_in, povy_ff, povy_in;
   logic        axis_ff, axis_in;
   logic [4:0]  k_ff, k_in;
   logic signed [63:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic signed [COORD_WIDTH-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_WIDTH-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic        overflow_ff, overflow_in;

   logic                  e_xform;
   logic [ADDR_W-1:0]     e_addr;
   logic [COEF_WIDTH-1:0] e_value;
   logic signed [63:0]    coef64, offq;
   logic [4:0]            n_sel, n_lim;
   logic [POW_W-1:0]      ex, ey;
   logic [64:0]           r1, r2;

   // Queue entry fields.
   assign e_xform = q_data[TOP];
   assign e_addr  = q_data[TOP-1:ADR_LO];
   assign e_value = q_data[ADR_LO-1:VAL_LO];

   // Coefficient views and term selection.
   assign coef64 = 64'(rd_data_ff);
   assign offq   = (coef64 >>> OFF_R) <<< OFF_L;
   assign n_sel  = axis_ff ? terms_y : terms_x;
   assign n_lim  = (n_sel > 5'(MAX_TERMS)) ? 5'(MAX_TERMS) : n_sel;
   assign ex     = exp_x(k_ff);
   assign ey     = exp_y(k_ff);

   // Read address follows the state so that the registered data is ready in the next cycle.
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  rd_addr = coef_addr(direction, 1'b0, 5'd0);
         ST_OFFX:  rd_addr = coef_addr(set_ff, 1'b1, 5'd0);
         ST_TSTART: begin
            if (k_ff > n_lim) rd_addr = coef_addr(~set_ff, axis_ff, 5'd0);
            else              rd_addr = coef_addr(set_ff, axis_ff, k_ff);
         end
         ST_MONO:  rd_addr = coef_addr(set_ff, axis_ff, k_ff);
         default:  rd_addr = coef_addr(~set_ff, axis_ff, 5'd0);
      endcase
   end

   // Coefficient store.
   always_ff @(posedge clock) begin
      if (we) begin
         coef_mem[e_addr] <= e_value;
      end
      rd_data_ff <= coef_mem[rd_addr];
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      set_in   = set_ff;
      ptx_in   = ptx_ff;
      pty_in   = pty_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      pl_in    = pl_ff;
      pol_in   = pol_ff;
      pwx_in   = pwx_ff;
      pwy_in   = pwy_ff;
      povx_in  = povx_ff;
      povy_in  = povy_ff;
      axis_in  = axis_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      overflow_in = overflow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      we       = 1'b0;
      q_ready  = 1'b0;
      mul_req  = '0;
      r1       = '0;
      r2       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               if (!e_xform) begin
                  we = 1'b1;
               end else begin
                  ptx_in   = q_data[PX_LO+COORD_WIDTH-1:PX_LO];
                  pty_in   = q_data[PY_LO+COORD_WIDTH-1:PY_LO];
                  set_in   = direction;
                  ovf_in   = 1'b0;
                  state_in = ST_OFFX;
               end
            end
         end
         ST_OFFX: begin
            r1       = clamp_c(64'(ptx_ff) - offq);
            cx_in    = r1[63:0];
            ovf_in   = ovf_ff | r1[64];
            state_in = ST_OFFY;
         end
         ST_OFFY: begin
            r1         = clamp_c(64'(pty_ff) - offq);
            cy_in      = r1[63:0];
            ovf_in     = ovf_ff | r1[64];
            pl_in      = ONE_Q;
            pol_in     = 1'b0;
            pwx_in[0]  = ONE_Q;
            pwy_in[0]  = ONE_Q;
            povx_in[0] = 1'b0;
            povy_in[0] = 1'b0;
            axis_in    = 1'b0;
            k_in       = 5'd1;
            state_in   = ST_PSTART;
         end
         ST_PSTART: begin
            mul_req.start      = 1'b1;
            mul_req.coef_shift = 1'b0;
            mul_req.a          = pl_ff;
            mul_req.b          = axis_ff ? cy_ff : cx_ff;
            state_in           = ST_PWAIT;
         end
         ST_PWAIT: begin
            if (mul_rsp.done) begin
               if (axis_ff) begin
                  pwy_in[k_ff[POW_W-1:0]]  = mul_rsp.value;
                  povy_in[k_ff[POW_W-1:0]] = pol_ff | mul_rsp.ovf;
               end else begin
                  pwx_in[k_ff[POW_W-1:0]]  = mul_rsp.value;
                  povx_in[k_ff[POW_W-1:0]] = pol_ff | mul_rsp.ovf;
               end
               pl_in  = mul_rsp.value;
               pol_in = pol_ff | mul_rsp.ovf;
               k_in   = k_ff + 5'd1;
               state_in = ST_PSTART;
               if (k_ff == 5'(NUM_POW - 1)) begin
                  k_in   = 5'd1;
                  pl_in  = ONE_Q;
                  pol_in = 1'b0;
                  if (axis_ff) begin
                     axis_in  = 1'b0;
                     acc_in   = 64'sd0;
                     state_in = ST_TSTART;
                  end else begin
                     axis_in  = 1'b1;
                  end
               end
            end
         end
         ST_TSTART: begin
            if (k_ff > n_lim) begin
               state_in = ST_OFFOUT;
            end else begin
               ovf_in             = ovf_ff | povx_ff[ex] | povy_ff[ey];
               mul_req.start      = 1'b1;
               mul_req.coef_shift = 1'b0;
               mul_req.a          = pwx_ff[ex];
               mul_req.b          = pwy_ff[ey];
               state_in           = ST_MONO;
            end
         end
         ST_MONO: begin
            if (mul_rsp.done) begin
               ovf_in             = ovf_ff | mul_rsp.ovf;
               mul_req.start      = 1'b1;
               mul_req.coef_shift = 1'b1;
               mul_req.a          = coef64;
               mul_req.b          = mul_rsp.value;
               state_in           = ST_TERM;
            end
         end
         ST_TERM: begin
            if (mul_rsp.done) begin
               r1       = sat_add(acc_ff, mul_rsp.value);
               acc_in   = r1[63:0];
               ovf_in   = ovf_ff | mul_rsp.ovf | r1[64];
               k_in     = k_ff + 5'd1;
               state_in = ST_TSTART;
            end
         end
         ST_OFFOUT: begin
            r1     = sat_add(acc_ff, offq);
            r2     = clamp_c(r1[63:0]);
            ovf_in = ovf_ff | r1[64] | r2[64];
            if (axis_ff) begin
               ry_in    = r2[COORD_WIDTH-1:0];
               state_in = ST_DONE;
            end else begin
               rx_in    = r2[COORD_WIDTH-1:0];
               axis_in  = 1'b1;
               k_in     = 5'd1;
               acc_in   = 64'sd0;
               state_in = ST_TSTART;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_x_in     = rx_ff;
               out_y_in     = ry_ff;
               overflow_in  = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      set_ff   <= set_in;
      ptx_ff   <= ptx_in;
      pty_ff   <= pty_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      pl_ff    <= pl_in;
      pol_ff   <= pol_in;
      pwx_ff   <= pwx_in;
      pwy_ff   <= pwy_in;
      povx_ff  <= povx_in;
      povy_ff  <= povy_in;
      axis_ff  <= axis_in;
      k_ff     <= k_in;
      acc_ff   <= acc_in;
      ovf_ff   <= ovf_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      overflow_ff <= overflow_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign overflow  = overflow_ff;

endmodule

/* src/poly2d_coordinate_transform_top.sv */
// ----------------------------------------------------------------------------
// poly2d_coordinate_transform_top
// Degree-5 bivariate polynomial coordinate warp in fixed point.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ stream. tuser selects the kind: a load writes
// one Q24.40 coefficient and gives no response, a transform takes a Q16.16
// point and gives one response on the rsp_ stream with the warped point and
// a saturation flag. The csr_ port writes direction, terms_x and terms_y,
// and is to be used only while no transform is in flight; the block itself
// does not enforce this. A two-entry queue separates intake from execution,
// so requests are taken while the back end works or a response waits. A
// load retires straight from the idle state. A transform runs one shared
// multiplier; each product takes an issue step, four 32x32 partial products
// and a round and saturate step. Each power of x and y takes one product
// and each term two (monomial, then coefficient); the powers come first,
// then the terms of x, then those of y. One transform runs at a time.
// Reset clears the control state and the registers to direction 0 and three
// terms per axis; the coefficient store is not cleared and must be loaded.
// A stalled response holds its data; the back end waits until it is taken
// before it gives the next response.
// ----------------------------------------------------------------------------
module poly2d_coordinate_transform_top #(
   parameter int MAX_TERMS   = p2ct_pkg::MAX_TERMS_DEF,
   parameter int COORD_WIDTH = p2ct_pkg::COORD_WIDTH_DEF,
   parameter int COEF_WIDTH  = p2ct_pkg::COEF_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // Request stream.
   input  logic req_tvalid,
   output logic req_tready,
   // coef_set, coef_axis, coef_index, coef_value, point_x, point_y, zero fill
   input  logic [((7+COEF_WIDTH+2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // cmd
   input  logic req_tuser,
   // Response stream.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_x, out_y, zero fill
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // overflow
   output logic rsp_tuser,
   // Configuration writes.
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_data
);
   import p2ct_pkg::*;

   localparam int ENTRY_W = 1 + ADDR_W + COEF_WIDTH + 2 * COORD_WIDTH;
   localparam int RSP_W   = ((2 * COORD_WIDTH + 7) / 8) * 8;

   logic               direction_ff;
   logic [4:0]         terms_x_ff, terms_y_ff;
   logic               f_valid, f_ready, b_valid, b_ready;
   logic [ENTRY_W-1:0] f_data, b_data;
   mul_req_type        mul_req;
   mul_rsp_type        mul_rsp;
   logic signed [COORD_WIDTH-1:0] out_x, out_y;
   logic               overflow;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         terms_x_ff   <= 5'd3;
         terms_y_ff   <= 5'd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DIRECTION: direction_ff <= csr_data[0];
            CSR_TERMS_X:   terms_x_ff   <= csr_data;
            CSR_TERMS_Y:   terms_y_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   p2ct_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_front (
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .q_valid   (f_valid),
      .q_ready   (f_ready),
      .q_data    (f_data)
   );

   p2ct_queue #(
      .DATA_W(ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_valid),
      .in_ready (f_ready),
      .in_data  (f_data),
      .out_valid(b_valid),
      .out_ready(b_ready),
      .out_data (b_data)
   );

   p2ct_mul #(
      .COEF_WIDTH(COEF_WIDTH)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .mul_req(mul_req),
      .mul_rsp(mul_rsp)
   );

   p2ct_back #(
      .MAX_TERMS  (MAX_TERMS),
      .COORD_WIDTH(COORD_WIDTH),
      .COEF_WIDTH (COEF_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (b_valid),
      .q_ready  (b_ready),
      .q_data   (b_data),
      .direction(direction_ff),
      .terms_x  (terms_x_ff),
      .terms_y  (terms_y_ff),
      .mul_req  (mul_req),
      .mul_rsp  (mul_rsp),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .out_x    (out_x),
      .out_y    (out_y),
      .overflow (overflow)
   );

   // Response packing.
   assign rsp_tdata = RSP_W'({out_y, out_x});
   assign rsp_tuser = overflow;

endmodule

/* src/p2ct_checker.sv */
// ----------------------------------------------------------------------------
// p2ct_checker
// Port-level checks of the coordinate transform, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module p2ct_checker #(
   parameter int COORD_WIDTH = p2ct_pkg::COORD_WIDTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input logic rsp_tuser,
   input logic csr_ready
);

   // No response is pending right after reset.
   `P2CT_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid)

   // A stalled response keeps its point and flag.
   `P2CT_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Handshake outputs are known out of reset, and configuration is always taken.
   `P2CT_ASSERT(a_ready_known, clock, reset, !$isunknown({req_tready, rsp_tvalid}) && csr_ready)

endmodule

bind poly2d_coordinate_transform_top p2ct_checker #(
   .COORD_WIDTH(COORD_WIDTH)
) u_p2ct_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the degree-5 polynomial coordinate warp.
// ----------------------------------------------------------------------------
// The coefficient store is filled first, so no entry is ever read before it
// is written. A short table then covers offsets, saturation in both
// directions, centring overflow and an ignored out-of-range load. Random
// phases follow, each under its own register setting. Every accepted
// request updates a bit-exact local copy of the block, and each response is
// compared field by field against the oldest predicted point.
// ----------------------------------------------------------------------------
module tb_top;
   import p2ct_pkg::*;

   typedef struct {
      logic             cmd;
      logic             set;
      logic             axis;
      logic [4:0]       idx;
      logic [63:0]      val;
      logic [31:0]      px;
      logic [31:0]      py;
   } request_type;

   typedef struct {
      logic [31:0] ox;
      logic [31:0] oy;
      logic        ov;
   } warp_point_type;

   typedef struct {
      request_type    rq;
      bit             typed;
      warp_point_type want;
   } table_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [4:0]   csr_data;

   // Local copy of the block: coefficient store and registers.
   logic [63:0]  coef_copy [NUM_COEF];
   logic         cur_dir;
   logic [4:0]   cur_terms_x;
   logic [4:0]   cur_terms_y;

   warp_point_type pending_points [$];
   int           fail_count = 0;
   int           req_count  = 0;
   int           rsp_count  = 0;

   // Powers of x and y used by each monomial, in the block's term order.
   int x_pow [ENTRIES] = '{0,0,1,0,1,2,0,2,1,3,0,2,3,1,4,0,3,2,4,1,5,0};
   int y_pow [ENTRIES] = '{0,0,0,1,1,0,2,1,2,0,3,2,1,3,0,4,2,3,1,4,0,5};

   poly2d_coordinate_transform_top dut (.*);

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on the run.
   initial begin
      #40ms;
      $display("Test completed with failures");
      $finish;
   end

   // Gap before a request: zero-gap stretches alternate with random gaps.
   function automatic int draw_gap(input int n);
      if ((n / 40) % 3 == 0) return 0;
      return $urandom_range(0, 11);
   endfunction

   // Product shifted right with floor, clamped to 64 bits.
   function automatic logic signed [63:0] mul_floor(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input int sh, inout bit ov);
      logic signed [127:0] p;
      p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      p = p >>> sh;
      if (p[127:63] != {65{p[63]}}) begin
         ov = 1'b1;
         return p[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return p[63:0];
   endfunction

   function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  inout bit ov);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         ov = 1'b1;
         return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] coord_clamp(input logic signed [63:0] v,
                                                      inout bit ov);
      if (v > 64'sd2147483647) begin
         ov = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ov = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Offset entry in coordinate format (floor shift from Q24.40).
   function automatic logic signed [63:0] offset_coord(input logic set, input logic axis);
      return $signed(coef_copy[(set * 2 + axis) * ENTRIES]) >>> 24;
   endfunction

   // Expected warped point for the current registers and store.
   function automatic warp_point_type warp_point(input logic [31:0] px,
                                                 input logic [31:0] py);
      logic signed [63:0] c [2];
      logic signed [63:0] pw [2][6];
      bit                 pov [2][6];
      logic signed [63:0] acc, mono, term;
      logic [4:0]         n;
      bit                 ov, o;
      warp_point_type     r;
      ov = 1'b0;
      c[0] = coord_clamp($signed({{32{px[31]}}, px}) - offset_coord(cur_dir, 1'b0), ov);
      c[1] = coord_clamp($signed({{32{py[31]}}, py}) - offset_coord(cur_dir, 1'b1), ov);
      for (int a = 0; a < 2; a++) begin
         pw[a][0] = ONE_Q;
         pov[a][0] = 1'b0;
         for (int k = 1; k < 6; k++) begin
            o = pov[a][k-1];
            pw[a][k] = mul_floor(pw[a][k-1], c[a], COORD_FRAC, o);
            pov[a][k] = o;
         end
      end
      for (int a = 0; a < 2; a++) begin
         n = (a == 0) ? cur_terms_x : cur_terms_y;
         if (n > 5'd21) n = 5'd21;
         acc = 64'sd0;
         for (int k = 1; k <= n; k++) begin
            if (pov[0][x_pow[k]] || pov[1][y_pow[k]]) ov = 1'b1;
            mono = mul_floor(pw[0][x_pow[k]], pw[1][y_pow[k]], COORD_FRAC, ov);
            term = mul_floor($signed(coef_copy[(cur_dir * 2 + a) * ENTRIES + k]), mono,
                             40, ov);
            acc = add_sat(acc, term, ov);
         end
         acc = add_sat(acc, offset_coord(~cur_dir, a[0]), ov);
         acc = coord_clamp(acc, ov);
         if (a == 0) r.ox = acc[31:0];
         else r.oy = acc[31:0];
      end
      r.ov = ov;
      return r;
   endfunction

   // Drive one request; on acceptance update the copy and queue any result.
   task automatic send_request(input request_type rq, input bit typed,
                               input warp_point_type want);
      int gap;
      gap = draw_gap(req_count);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= rq.cmd;
      req_tdata  <= {1'b0, rq.py, rq.px, rq.val, rq.idx, rq.axis, rq.set};
      do @(posedge clock); while (!req_tready);
      req_count++;
      if (rq.cmd == CMD_LOAD) begin
         if (rq.idx < ENTRIES) coef_copy[(rq.set * 2 + rq.axis) * ENTRIES + rq.idx] = rq.val;
      end else begin
         pending_points.push_back(typed ? want : warp_point(rq.px, rq.py));
      end
   endtask

   // Write one register; the caller drops csr_valid after the last write.
   task automatic write_csr(input logic [1:0] index, input logic [4:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_DIRECTION: cur_dir = data[0];
         CSR_TERMS_X:   cur_terms_x = data;
         CSR_TERMS_Y:   cur_terms_y = data;
         default: ;
      endcase
   endtask

   // Let every response drain, then wait for a trailing load.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_coef();
      return $signed({$urandom, $urandom}) >>> $urandom_range(0, 63);
   endfunction

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 9) < 2) return $urandom;
      return $signed($urandom) >>> $urandom_range(10, 31);
   endfunction

   // Response side: random stalls, then compare with the oldest prediction.
   initial begin
      warp_point_type want;
      int             gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = draw_gap(rsp_count + 20);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_count++;
         if (pending_points.size() == 0) begin
            $error("response with no request waiting: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_points.pop_front();
            if (rsp_tdata[31:0] != want.ox) begin
               $error("out_x expected %h actual %h", want.ox, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[63:32] != want.oy) begin
               $error("out_y expected %h actual %h", want.oy, rsp_tdata[63:32]);
               fail_count++;
            end
            if (rsp_tuser != want.ov) begin
               $error("overflow expected %b actual %b", want.ov, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // Stimulus.
   initial begin
      table_row_type  rows [];
      request_type    rq;
      warp_point_type none;
      logic [4:0]     tx, ty;
      logic           dr;
      int             r;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_LOAD;
      csr_valid  = 1'b0;
      csr_index  = CSR_DIRECTION;
      csr_data   = '0;
      cur_dir     = 1'b0;
      cur_terms_x = 5'd3;
      cur_terms_y = 5'd3;
      none = '{32'd0, 32'd0, 1'b0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Clear the whole store so every later read is of a written entry.
      for (int i = 0; i < NUM_COEF; i++) begin
         rq = '{CMD_LOAD, 1'(i / 44), 1'((i / 22) % 2), 5'(i % 22), 64'd0, 32'd0, 32'd0};
         send_request(rq, 1'b0, none);
      end

      // Directed cases under the reset setting (direct set, three terms).
      rows = '{
         // All zero: origin and the extreme corners map to zero.
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'd0, 32'd0}, 1, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'h7fffffff, 32'h80000000}, 1, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'h80000000, 32'h7fffffff}, 1, '{0, 0, 0}},
         // Constant term 1.0 on x, output offset 5.0 from the inverse set.
         '{'{CMD_LOAD, 0, 0, 5'd1, 64'h100_0000_0000, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         '{'{CMD_LOAD, 1, 0, 5'd0, 64'h500_0000_0000, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'd0, 32'd0}, 1, '{32'h60000, 0, 0}},
         // Largest and smallest x coefficient on y saturate the output.
         '{'{CMD_LOAD, 0, 1, 5'd2, 64'h7fffffffffffffff, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'h7fffffff, 32'd0}, 1,
           '{32'h60000, 32'h7fffffff, 1}},
         '{'{CMD_LOAD, 0, 1, 5'd2, 64'h8000000000000000, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'h7fffffff, 32'd0}, 1,
           '{32'h60000, 32'h80000000, 1}},
         '{'{CMD_LOAD, 0, 1, 5'd2, 64'd0, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         // Huge negative centring offset overflows the centred x.
         '{'{CMD_LOAD, 0, 0, 5'd0, 64'h8000000000000000, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'd0, 32'd0}, 1, '{32'h60000, 0, 1}},
         '{'{CMD_LOAD, 0, 0, 5'd0, 64'd0, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         // A load beyond the last entry changes nothing.
         '{'{CMD_LOAD, 0, 0, 5'd31, 64'hffffffffffffffff, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'd0, 32'd0}, 1, '{32'h60000, 0, 0}},
         // Ordinary points, checked by prediction.
         '{'{CMD_LOAD, 0, 0, 5'd2, 64'hffffff8000000000, 32'd0, 32'd0}, 0, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'h00030000, 32'hfffe8000}, 0, '{0, 0, 0}},
         '{'{CMD_TRANSFORM, 0, 0, 5'd0, 64'd0, 32'h80000000, 32'h80000000}, 0, '{0, 0, 0}}
      };
      foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].want);

      // Random phases, each with its own register setting.
      for (int p = 0; p < 10; p++) begin
         wait_idle();
         case (p)
            0: begin dr = 1'b0; tx = 5'd2;  ty = 5'd2;  end
            1: begin dr = 1'b1; tx = 5'd21; ty = 5'd21; end
            2: begin dr = 1'b0; tx = 5'd21; ty = 5'd2;  end
            3: begin dr = 1'b1; tx = 5'd2;  ty = 5'd21; end
            default: begin
               dr = 1'($urandom_range(0, 1));
               tx = 5'($urandom_range(2, 21));
               ty = 5'($urandom_range(2, 21));
            end
         endcase
         write_csr(CSR_DIRECTION, {4'd0, dr});
         write_csr(CSR_TERMS_X, tx);
         write_csr(CSR_TERMS_Y, ty);
         csr_valid <= 1'b0;
         for (int i = 0; i < 125; i++) begin
            r = $urandom_range(0, 99);
            rq.set  = 1'($urandom_range(0, 1));
            rq.axis = 1'($urandom_range(0, 1));
            rq.val  = rand_coef();
            rq.px   = rand_coord();
            rq.py   = rand_coord();
            if (r < 55) begin
               rq.cmd = CMD_LOAD;
               rq.idx = 5'($urandom_range(0, 21));
            end else if (r < 60) begin
               rq.cmd = CMD_LOAD;
               rq.idx = 5'($urandom_range(22, 31));
            end else begin
               rq.cmd = CMD_TRANSFORM;
               rq.idx = 5'($urandom_range(0, 31));
            end
            send_request(rq, 1'b0, none);
         end
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
